>>> rtl/core/srsg_pkg.sv
// Package for the servo raster scan generator: sequencer states, register map, reset values.
package srsg_pkg;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_AZ_MOVE = 9'b000000010,
        ST_AZ_CHK  = 9'b000000100,
        ST_EL_CHK  = 9'b000001000,
        ST_DIV_A   = 9'b000010000,
        ST_WAIT_A  = 9'b000100000,
        ST_DIV_E   = 9'b001000000,
        ST_WAIT_E  = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

    localparam int ADDR_BITS = 5;

    typedef enum logic [2:0] {
        REG_AZ_LIMIT  = 3'd0,
        REG_EL_LIMIT  = 3'd1,
        REG_STEP      = 3'd2,
        REG_AZ_CENTER = 3'd3,
        REG_EL_CENTER = 3'd4
    } reg_index_t;

    localparam logic [6:0]  AZ_LIMIT_RESET  = 7'd20;
    localparam logic [6:0]  EL_LIMIT_RESET  = 7'd20;
    localparam logic [7:0]  STEP_RESET      = 8'd30;
    localparam logic [15:0] AZ_CENTER_RESET = 16'd4700;
    localparam logic [15:0] EL_CENTER_RESET = 16'd4600;

    localparam int ANGLE_BITS = 9;
    localparam int DUTY_BITS  = 16;
    localparam int OUT_BITS   = 56;

endpackage

>>> rtl/core/srsg_div.sv
// Bit-serial restoring divider: unsigned magnitude by an 8-bit divisor, one bit a cycle.
module srsg_div #(
    parameter int POSITION_BITS = 17
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [POSITION_BITS-1:0] dividend,
    input  logic [7:0]               divisor,
    output logic                     done,
    output logic [POSITION_BITS-1:0] quotient
);

    localparam int CNTW = $clog2(POSITION_BITS);

    logic                     busy_reg;
    logic                     done_reg;
    logic [CNTW-1:0]          count_reg;
    logic [7:0]               rem_reg;
    logic [POSITION_BITS-1:0] quo_reg;

    logic [8:0] trial;
    logic [8:0] diff;
    logic       q_bit;

    always_comb begin
        trial = {rem_reg, quo_reg[POSITION_BITS-1]};
        diff  = trial - {1'b0, divisor};
        q_bit = (trial >= {1'b0, divisor});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= busy_reg && !start && (count_reg == '0);
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= CNTW'(POSITION_BITS - 1);
            end else if (busy_reg) begin
                if (count_reg == '0) begin
                    busy_reg <= 1'b0;
                end else begin
                    count_reg <= count_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= q_bit ? diff[7:0] : trial[7:0];
            quo_reg <= {quo_reg[POSITION_BITS-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/core/servo_raster_scan_generator_top.sv
// Servo raster scan generator: position sequencer, shared bound check, serial angle divider.
// The bit-serial divider runs once per axis, one quotient bit a cycle.
// Throughput: one transfer at a time; s_tready is high only while the sequencer is idle.
// Reset (aresetn low, synchronous): positions zero, both axes counting upward, registers at
// their defaults, no result pending.
module servo_raster_scan_generator_top #(
    parameter int POSITION_BITS = 17
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [srsg_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [0] tick, [7:1] zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] azimuth_duty, [31:16] elevation_duty, [40:32] azimuth_angle,
    // [49:41] elevation_angle, [55:50] zero
    output logic [srsg_pkg::OUT_BITS-1:0]  m_tdata
);

    localparam int P  = POSITION_BITS;
    localparam int CW = ((P > 16) ? P : 16) + 2;

    srsg_pkg::state_t state_reg;

    logic [6:0]  az_limit_reg;
    logic [6:0]  el_limit_reg;
    logic [7:0]  step_reg;
    logic [15:0] az_center_reg;
    logic [15:0] el_center_reg;

    logic [P-1:0] az_pos_reg;
    logic [P-1:0] el_pos_reg;
    logic         az_rev_reg;
    logic         el_rev_reg;

    logic [srsg_pkg::ANGLE_BITS-1:0] az_angle_reg;
    logic [srsg_pkg::ANGLE_BITS-1:0] el_angle_reg;

    logic                         m_tvalid_reg;
    logic [srsg_pkg::OUT_BITS-1:0] m_tdata_reg;

    logic cfg_write;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            az_limit_reg  <= srsg_pkg::AZ_LIMIT_RESET;
            el_limit_reg  <= srsg_pkg::EL_LIMIT_RESET;
            step_reg      <= srsg_pkg::STEP_RESET;
            az_center_reg <= srsg_pkg::AZ_CENTER_RESET;
            el_center_reg <= srsg_pkg::EL_CENTER_RESET;
        end else if (cfg_write) begin
            unique case (paddr[4:2])
                srsg_pkg::REG_AZ_LIMIT:  az_limit_reg  <= pwdata[6:0];
                srsg_pkg::REG_EL_LIMIT:  el_limit_reg  <= pwdata[6:0];
                srsg_pkg::REG_STEP:      step_reg      <= pwdata[7:0];
                srsg_pkg::REG_AZ_CENTER: az_center_reg <= pwdata[15:0];
                srsg_pkg::REG_EL_CENTER: el_center_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            srsg_pkg::REG_AZ_LIMIT:  prdata = {25'd0, az_limit_reg};
            srsg_pkg::REG_EL_LIMIT:  prdata = {25'd0, el_limit_reg};
            srsg_pkg::REG_STEP:      prdata = {24'd0, step_reg};
            srsg_pkg::REG_AZ_CENTER: prdata = {16'd0, az_center_reg};
            srsg_pkg::REG_EL_CENTER: prdata = {16'd0, el_center_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // shared bound check: azimuth in ST_AZ_CHK, elevation otherwise
    logic [P-1:0]  chk_pos;
    logic [6:0]    chk_limit;
    logic [14:0]   bound;
    logic [CW-1:0] chk_pos_x;
    logic [CW-1:0] bound_x;
    logic          outside;

    always_comb begin
        chk_pos   = (state_reg == srsg_pkg::ST_AZ_CHK) ? az_pos_reg : el_pos_reg;
        chk_limit = (state_reg == srsg_pkg::ST_AZ_CHK) ? az_limit_reg : el_limit_reg;
        bound     = 15'(chk_limit * step_reg);
        chk_pos_x = CW'($signed(chk_pos));
        bound_x   = CW'(bound);
        outside   = ($signed(chk_pos_x) > $signed(bound_x)) ||
                    ($signed(chk_pos_x) < -$signed(bound_x));
    end

    // divider shared by both axes
    logic         div_start;
    logic         div_done;
    logic [P-1:0] div_quo;
    logic [P-1:0] div_pos;
    logic [P-1:0] div_mag;
    logic         div_neg;

    always_comb begin
        div_start = (state_reg == srsg_pkg::ST_DIV_A) || (state_reg == srsg_pkg::ST_DIV_E);
        div_pos   = (state_reg == srsg_pkg::ST_DIV_A || state_reg == srsg_pkg::ST_WAIT_A)
                    ? az_pos_reg : el_pos_reg;
        div_neg   = div_pos[P-1];
        div_mag   = div_neg ? (~div_pos + 1'b1) : div_pos;
    end

    srsg_div #(
        .POSITION_BITS(P)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_mag),
        .divisor  (step_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    logic [srsg_pkg::ANGLE_BITS-1:0] angle;

    always_comb begin
        if (step_reg == 8'd0) begin
            angle = '0;
        end else if (!div_neg) begin
            angle = (div_quo > P'(255)) ? 9'd255 : div_quo[8:0];
        end else begin
            angle = (div_quo > P'(256)) ? 9'h100 : (~div_quo[8:0] + 1'b1);
        end
    end

    // duty saturation
    logic [CW-1:0] az_sum;
    logic [CW-1:0] el_sum;
    logic [15:0]   az_duty;
    logic [15:0]   el_duty;

    always_comb begin
        az_sum = CW'(az_center_reg) + CW'($signed(az_pos_reg));
        el_sum = CW'(el_center_reg) + CW'($signed(el_pos_reg));
        if ($signed(az_sum) < 0)                 az_duty = 16'd0;
        else if ($signed(az_sum) > CW'(65535))   az_duty = 16'hFFFF;
        else                                     az_duty = az_sum[15:0];
        if ($signed(el_sum) < 0)                 el_duty = 16'd0;
        else if ($signed(el_sum) > CW'(65535))   el_duty = 16'hFFFF;
        else                                     el_duty = el_sum[15:0];
    end

    logic s_xfer;
    logic out_free;
    assign s_tready = (state_reg == srsg_pkg::ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= srsg_pkg::ST_IDLE;
            az_pos_reg   <= '0;
            el_pos_reg   <= '0;
            az_rev_reg   <= 1'b0;
            el_rev_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == srsg_pkg::ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                srsg_pkg::ST_IDLE: begin
                    if (s_xfer) begin
                        state_reg <= s_tdata[0] ? srsg_pkg::ST_AZ_MOVE : srsg_pkg::ST_DIV_A;
                    end
                end
                srsg_pkg::ST_AZ_MOVE: begin
                    az_pos_reg <= az_rev_reg ? (az_pos_reg - 1'b1) : (az_pos_reg + 1'b1);
                    state_reg  <= srsg_pkg::ST_AZ_CHK;
                end
                srsg_pkg::ST_AZ_CHK: begin
                    if (outside) begin
                        az_rev_reg <= !az_rev_reg;
                        el_pos_reg <= el_rev_reg ? (el_pos_reg - P'(step_reg))
                                                 : (el_pos_reg + P'(step_reg));
                        state_reg  <= srsg_pkg::ST_EL_CHK;
                    end else begin
                        state_reg  <= srsg_pkg::ST_DIV_A;
                    end
                end
                srsg_pkg::ST_EL_CHK: begin
                    if (outside) begin
                        el_rev_reg <= !el_rev_reg;
                    end
                    state_reg <= srsg_pkg::ST_DIV_A;
                end
                srsg_pkg::ST_DIV_A: state_reg <= srsg_pkg::ST_WAIT_A;
                srsg_pkg::ST_WAIT_A: begin
                    if (div_done) begin
                        state_reg <= srsg_pkg::ST_DIV_E;
                    end
                end
                srsg_pkg::ST_DIV_E: state_reg <= srsg_pkg::ST_WAIT_E;
                srsg_pkg::ST_WAIT_E: begin
                    if (div_done) begin
                        state_reg <= srsg_pkg::ST_DONE;
                    end
                end
                srsg_pkg::ST_DONE: begin
                    if (out_free) begin
                        state_reg <= srsg_pkg::ST_IDLE;
                    end
                end
                default: state_reg <= srsg_pkg::ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == srsg_pkg::ST_WAIT_A && div_done) begin
            az_angle_reg <= angle;
        end
        if (state_reg == srsg_pkg::ST_WAIT_E && div_done) begin
            el_angle_reg <= angle;
        end
        if (state_reg == srsg_pkg::ST_DONE && out_free) begin
            m_tdata_reg <= {6'd0, el_angle_reg, az_angle_reg, el_duty, az_duty};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == srsg_pkg::ST_WAIT_A || state_reg == srsg_pkg::ST_WAIT_E))
        else $error("divider finished outside a wait state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_tready)
        else $error("sequencer still ready after an input transfer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == srsg_pkg::ST_DONE))
        else $error("result raised without finishing the sequence");

endmodule

>>> sim/servo_scan_checker.sv
// Checker for the servo raster scan generator: register shadow, scan predictor, result compare.
module servo_scan_checker #(
    parameter int POSITION_BITS = 17
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [srsg_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    input  logic                           pready,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [srsg_pkg::OUT_BITS-1:0]  m_tdata,
    output int                             errors,
    output int                             pending,
    output int                             compared
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint DUTY_MAX  = (longint'(1) << srsg_pkg::DUTY_BITS) - 1;
    localparam longint ANGLE_MAX = (longint'(1) << (srsg_pkg::ANGLE_BITS - 1)) - 1;
    localparam longint ANGLE_MIN = -(longint'(1) << (srsg_pkg::ANGLE_BITS - 1));

    typedef struct packed {
        logic [srsg_pkg::ANGLE_BITS-1:0] el_angle;
        logic [srsg_pkg::ANGLE_BITS-1:0] az_angle;
        logic [srsg_pkg::DUTY_BITS-1:0]  el_duty;
        logic [srsg_pkg::DUTY_BITS-1:0]  az_duty;
    } servo_cmd_t;

    logic [6:0]  az_limit;
    logic [6:0]  el_limit;
    logic [7:0]  step;
    logic [15:0] az_center;
    logic [15:0] el_center;

    logic signed [POSITION_BITS-1:0] az_pos;
    logic signed [POSITION_BITS-1:0] el_pos;
    logic                            az_rev;
    logic                            el_rev;

    servo_cmd_t servo_cmd_q[$];
    int         err_count = 0;
    int         cmd_count = 0;

    function automatic bit past_bound(logic signed [POSITION_BITS-1:0] pos, logic [6:0] lim);
        longint bound;
        bound = longint'(lim) * longint'(step);
        return (longint'(pos) > bound) || (longint'(pos) < -bound);
    endfunction

    function automatic logic [srsg_pkg::DUTY_BITS-1:0] duty_sat(logic [15:0] center,
                                                      logic signed [POSITION_BITS-1:0] pos);
        longint d;
        d = longint'(center) + longint'(pos);
        if (d < 0) d = 0;
        if (d > DUTY_MAX) d = DUTY_MAX;
        return d[srsg_pkg::DUTY_BITS-1:0];
    endfunction

    function automatic logic [srsg_pkg::ANGLE_BITS-1:0] angle_of(
            logic signed [POSITION_BITS-1:0] pos);
        longint a;
        if (step == '0) return '0;
        a = longint'(pos) / longint'(step);
        if (a > ANGLE_MAX) a = ANGLE_MAX;
        if (a < ANGLE_MIN) a = ANGLE_MIN;
        return a[srsg_pkg::ANGLE_BITS-1:0];
    endfunction

    task automatic advance_scan(input logic tick);
        servo_cmd_t cmd;
        if (tick) begin
            az_pos = az_rev ? az_pos - 1'b1 : az_pos + 1'b1;
            if (past_bound(az_pos, az_limit)) begin
                az_rev = !az_rev;
                el_pos = el_rev ? el_pos - step : el_pos + step;
                if (past_bound(el_pos, el_limit)) el_rev = !el_rev;
            end
        end
        cmd.az_duty  = duty_sat(az_center, az_pos);
        cmd.el_duty  = duty_sat(el_center, el_pos);
        cmd.az_angle = angle_of(az_pos);
        cmd.el_angle = angle_of(el_pos);
        servo_cmd_q.push_back(cmd);
    endtask

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got) begin
            err_count++;
            if (err_count <= 40)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        servo_cmd_t want;
        servo_cmd_t got;
        if (!aresetn) begin
            az_limit  = srsg_pkg::AZ_LIMIT_RESET;
            el_limit  = srsg_pkg::EL_LIMIT_RESET;
            step      = srsg_pkg::STEP_RESET;
            az_center = srsg_pkg::AZ_CENTER_RESET;
            el_center = srsg_pkg::EL_CENTER_RESET;
            az_pos    = '0;
            el_pos    = '0;
            az_rev    = 1'b0;
            el_rev    = 1'b0;
            servo_cmd_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (srsg_pkg::reg_index_t'(paddr[srsg_pkg::ADDR_BITS-1:2]))
                    srsg_pkg::REG_AZ_LIMIT:  az_limit  = pwdata[6:0];
                    srsg_pkg::REG_EL_LIMIT:  el_limit  = pwdata[6:0];
                    srsg_pkg::REG_STEP:      step      = pwdata[7:0];
                    srsg_pkg::REG_AZ_CENTER: az_center = pwdata[15:0];
                    srsg_pkg::REG_EL_CENTER: el_center = pwdata[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = servo_cmd_t'(m_tdata[$bits(servo_cmd_t)-1:0]);
                if (servo_cmd_q.size() == 0) begin
                    err_count++;
                    $display("%0t ns: unexpected transfer, expected none, actual %h",
                             $time, m_tdata);
                end else begin
                    want = servo_cmd_q.pop_front();
                    cmd_count++;
                    check_field("azimuth_duty", want.az_duty, got.az_duty);
                    check_field("elevation_duty", want.el_duty, got.el_duty);
                    check_field("azimuth_angle", $signed(want.az_angle), $signed(got.az_angle));
                    check_field("elevation_angle", $signed(want.el_angle),
                                $signed(got.el_angle));
                end
            end
            if (s_tvalid && s_tready) advance_scan(s_tdata[0]);
        end
        errors   <= err_count;
        pending  <= servo_cmd_q.size();
        compared <= cmd_count;
    end

endmodule

>>> sim/tb.sv
// Testbench top for the servo raster scan generator: stimulus, pacing, watchdog and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_BITS    = 17;
    localparam int SETTLE      = 2 * POS_BITS + 12;
    localparam int WATCHDOG    = 4000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 100;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [srsg_pkg::ADDR_BITS-1:0] paddr    = '0;
    logic [31:0]                    pwdata   = '0;
    logic [31:0]                    prdata;
    logic                           pready;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [srsg_pkg::OUT_BITS-1:0]  m_tdata;

    int errors;
    int pending;
    int compared;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int stuck       = 0;
    int sent        = 0;
    int writes_done = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    servo_raster_scan_generator_top #(
        .POSITION_BITS(POS_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    servo_scan_checker #(
        .POSITION_BITS(POS_BITS)
    ) u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending),
        .compared (compared)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            stuck <= 0;
        end else if (stuck >= WATCHDOG) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    // upper bits beyond the register width get random junk half the time
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value, input int width);
        logic [31:0] keep;
        keep = (32'd1 << width) - 32'd1;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom_range(0, 1) ? ($urandom & ~keep) : 32'd0) | (value & keep);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        writes_done++;
    endtask

    task automatic send_tick(input logic tick);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, tick};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        int p;
        int i;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults, both tick values
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        wait_drained();
        // zero step: angles stay zero, elevation never moves
        write_reg(srsg_pkg::REG_STEP, 32'd0, 8);
        write_reg(srsg_pkg::REG_AZ_LIMIT, 32'd0, 7);
        repeat (3) send_tick(1'b1);
        send_tick(1'b0);
        wait_drained();
        // write beyond the register list is dropped
        write_reg(3'(srsg_pkg::REG_EL_CENTER + 1), $urandom, 0);
        write_reg(srsg_pkg::REG_STEP, 32'd1, 8);
        repeat (2) send_tick(1'b1);
        wait_drained();
        // max step, zero bounds, duty saturation both ways
        write_reg(srsg_pkg::REG_STEP, 32'd255, 8);
        write_reg(srsg_pkg::REG_EL_LIMIT, 32'd0, 7);
        write_reg(srsg_pkg::REG_AZ_CENTER, 32'hFFFF, 16);
        write_reg(srsg_pkg::REG_EL_CENTER, 32'd0, 16);
        repeat (6) send_tick(1'b1);
        wait_drained();
        write_reg(srsg_pkg::REG_AZ_CENTER, 32'd0, 16);
        write_reg(srsg_pkg::REG_EL_CENTER, 32'hFFFF, 16);
        repeat (4) send_tick(1'b1);

        for (p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 76; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 76; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            case (p % 6)
                0: begin
                    write_reg(srsg_pkg::REG_AZ_LIMIT, $urandom_range(0, 3), 7);
                    write_reg(srsg_pkg::REG_EL_LIMIT, $urandom_range(0, 3), 7);
                    write_reg(srsg_pkg::REG_STEP, $urandom_range(1, 4), 8);
                    write_reg(srsg_pkg::REG_AZ_CENTER, $urandom_range(0, 65535), 16);
                    write_reg(srsg_pkg::REG_EL_CENTER, $urandom_range(0, 65535), 16);
                end
                1: begin
                    // one row per tick, large elevation swing
                    write_reg(srsg_pkg::REG_AZ_LIMIT, 32'd0, 7);
                    write_reg(srsg_pkg::REG_EL_LIMIT, 32'd20, 7);
                    write_reg(srsg_pkg::REG_STEP, 32'd255, 8);
                    write_reg(srsg_pkg::REG_AZ_CENTER, 32'hFFFF, 16);
                    write_reg(srsg_pkg::REG_EL_CENTER, 32'd0, 16);
                end
                2: begin
                    // step drops under a far-out elevation: angle clamps, bounds lowered
                    write_reg(srsg_pkg::REG_STEP, 32'd1, 8);
                    write_reg(srsg_pkg::REG_AZ_LIMIT, 32'd0, 7);
                    write_reg(srsg_pkg::REG_EL_LIMIT, 32'd0, 7);
                    write_reg(srsg_pkg::REG_AZ_CENTER, 32'd0, 16);
                    write_reg(srsg_pkg::REG_EL_CENTER, 32'hFFFF, 16);
                end
                3: begin
                    write_reg(srsg_pkg::REG_AZ_LIMIT, 32'd127, 7);
                    write_reg(srsg_pkg::REG_EL_LIMIT, 32'd127, 7);
                    write_reg(srsg_pkg::REG_STEP, 32'd255, 8);
                    write_reg(srsg_pkg::REG_AZ_CENTER, $urandom_range(0, 65535), 16);
                    write_reg(srsg_pkg::REG_EL_CENTER, $urandom_range(0, 65535), 16);
                end
                4: begin
                    write_reg(srsg_pkg::REG_AZ_LIMIT, $urandom_range(0, 2), 7);
                    write_reg(srsg_pkg::REG_EL_LIMIT, 32'd1, 7);
                    write_reg(srsg_pkg::REG_STEP, 32'd0, 8);
                end
                default: begin
                    write_reg(srsg_pkg::REG_AZ_LIMIT, $urandom_range(0, 8), 7);
                    write_reg(srsg_pkg::REG_EL_LIMIT, $urandom_range(0, 8), 7);
                    write_reg(srsg_pkg::REG_STEP, $urandom_range(0, 16), 8);
                    write_reg(srsg_pkg::REG_AZ_CENTER, $urandom_range(0, 65535), 16);
                    write_reg(srsg_pkg::REG_EL_CENTER, $urandom_range(0, 65535), 16);
                end
            endcase
            if ($urandom_range(0, 1))
                write_reg(3'(srsg_pkg::REG_EL_CENTER + 1 + $urandom_range(0, 2)), $urandom, 0);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 59) == 0) wait_drained();
                send_tick($urandom_range(0, 99) < 85);
            end
        end
        wait_drained();

        $display("Sent %0d ticks with %0d register writes over four pacing modes; %0d compared.",
                 sent, writes_done, compared);
        $display("Settings spanned zero and maximum step, zero and maximum bounds, duty extremes.");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
